### design/lnt_pkg.sv
// ----------------------------------------------------------------------------
// lnt_pkg
// shared types and constants of the lattice noise turbulence unit
// ----------------------------------------------------------------------------
package lnt_pkg;

    localparam int LAT_BITS         = 6;
    localparam int LATTICE_SIZE     = 1 << LAT_BITS;
    localparam int ADDR_BITS        = 3 * LAT_BITS;
    localparam int ENTRY_COUNT      = LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE;
    localparam int VALUE_BITS       = 16;
    localparam int POINT_BITS       = 32;
    localparam int SUM_BITS         = 17;
    localparam int CFG_BITS         = 5;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_MAX_OCTAVES  = 16;
    localparam logic [CFG_BITS-1:0] OCTAVES_RESET = CFG_BITS'(1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

endpackage

### design/lattice_noise_turbulence_unit.sv
// ----------------------------------------------------------------------------
// lattice_noise_turbulence_unit
// value noise turbulence over a 64^3 lattice of 16-bit fractions
// ----------------------------------------------------------------------------
// A write transaction stores one lattice entry in the cycle it is accepted and
// leaves busy low. An evaluate transaction holds busy high and runs, for each
// octave, eight corner reads from the single port of the lattice memory,
// overlapped with the first four of seven interpolations through one shared
// multiply-add unit, then one accumulate.
// With N octaves the result strobe o_valid follows the last accumulate; with N
// zero it comes in the cycle after start. The result is shown for exactly one
// cycle and cannot be held off; busy is already low in that cycle, so the next
// transaction can start while the result is on the ports. No clearing pass
// runs after reset: an entry must be written before any evaluate reads it.
module lattice_noise_turbulence_unit #(
    parameter int FRACTION_BITS = lnt_pkg::DEF_FRACTION_BITS,
    parameter int MAX_OCTAVES   = lnt_pkg::DEF_MAX_OCTAVES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic [lnt_pkg::ADDR_BITS-1:0]    i_entry_index,
    input  logic [lnt_pkg::VALUE_BITS-1:0]   i_entry_value,
    input  logic [lnt_pkg::POINT_BITS-1:0]   i_point_x,
    input  logic [lnt_pkg::POINT_BITS-1:0]   i_point_y,
    input  logic [lnt_pkg::POINT_BITS-1:0]   i_point_z,
    output logic                             o_valid,
    output logic [lnt_pkg::SUM_BITS-1:0]     o_noise_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lnt_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import lnt_pkg::*;

    localparam int PW   = FRACTION_BITS + LAT_BITS;
    localparam int KW   = $clog2(MAX_OCTAVES + 1);
    localparam int MW   = VALUE_BITS + FRACTION_BITS + 2;
    localparam logic [3:0] STEP_FACE_HI = 4'd9;
    localparam logic [3:0] STEP_FACE_LO = 4'd10;
    localparam logic [3:0] STEP_DEPTH   = 4'd11;
    localparam logic [3:0] STEP_ACCUM   = 4'd12;
    localparam logic [CFG_BITS-1:0] MAX_OCT = CFG_BITS'(MAX_OCTAVES);

    logic [VALUE_BITS-1:0] r_mem [ENTRY_COUNT];
    logic [VALUE_BITS-1:0] r_rdata;
    logic [ADDR_BITS-1:0]  rd_addr;

    t_state r_state, n_state;
    logic [CFG_BITS-1:0] r_octaves;
    logic [KW-1:0]       r_k, n_k;
    logic [KW-1:0]       r_oct_eval, n_oct_eval;
    logic [3:0]          r_step, n_step;
    logic [PW-1:0]       r_px, r_py, r_pz;
    logic [PW-1:0]       n_px, n_py, n_pz;
    logic [VALUE_BITS-1:0] r_a, r_p0, r_p1, r_p2, r_p3;
    logic [VALUE_BITS-1:0] n_a, n_p0, n_p1, n_p2, n_p3;
    logic [SUM_BITS-1:0] r_sum, n_sum;
    logic                r_valid, n_valid;
    logic [SUM_BITS-1:0] r_noise, n_noise;

    logic accept;
    logic [CFG_BITS-1:0] oct_sat;
    logic [LAT_BITS-1:0] x0, y0, z0, x1, y1, z1, cx, cy, cz;
    logic [VALUE_BITS-1:0] lerp_a, lerp_b, lerp_q;
    logic [FRACTION_BITS-1:0] lerp_t;
    logic signed [VALUE_BITS:0]      lerp_d;
    logic signed [MW-1:0]            lerp_m;
    logic [SUM_BITS-1:0] oct_add;

    assign accept      = start && !busy;
    assign busy        = (r_state == S_RUN);
    assign o_valid     = r_valid;
    assign o_noise_value = r_noise;
    assign o_cfg_ready = 1'b1;
    assign oct_sat     = (r_octaves > MAX_OCT) ? MAX_OCT : r_octaves;

    // lattice coordinates of the current octave
    assign x0 = r_px[PW-1:FRACTION_BITS];
    assign y0 = r_py[PW-1:FRACTION_BITS];
    assign z0 = r_pz[PW-1:FRACTION_BITS];
    assign x1 = x0 + LAT_BITS'(1);
    assign y1 = y0 + LAT_BITS'(1);
    assign z1 = z0 + LAT_BITS'(1);

    // corner order: y pairs at (x0,z1), (x1,z1), (x0,z0), (x1,z0)
    assign cy = r_step[0] ? y1 : y0;
    assign cx = r_step[1] ? x1 : x0;
    assign cz = r_step[2] ? z0 : z1;
    assign rd_addr = {cx, cy, cz};

    always_ff @(posedge i_clk) begin
        if (accept && (t_op'(i_operation) == OP_WRITE)) begin
            r_mem[i_entry_index] <= i_entry_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // shared interpolation unit: a + floor((b - a) * t / 2^F)
    always_comb begin
        unique case (r_step)
            STEP_FACE_HI: begin
                lerp_a = r_p0;
                lerp_b = r_p1;
                lerp_t = r_px[FRACTION_BITS-1:0];
            end
            STEP_FACE_LO: begin
                lerp_a = r_p2;
                lerp_b = r_p3;
                lerp_t = r_px[FRACTION_BITS-1:0];
            end
            STEP_DEPTH: begin
                lerp_a = r_p2;
                lerp_b = r_p0;
                lerp_t = r_pz[FRACTION_BITS-1:0];
            end
            default: begin
                lerp_a = r_a;
                lerp_b = r_rdata;
                lerp_t = r_py[FRACTION_BITS-1:0];
            end
        endcase
        lerp_d = $signed({1'b0, lerp_b}) - $signed({1'b0, lerp_a});
        lerp_m = MW'(lerp_d) * $signed({1'b0, lerp_t});
        lerp_q = lerp_a + VALUE_BITS'(lerp_m >>> FRACTION_BITS);
    end

    assign oct_add = SUM_BITS'(r_a >> r_k);

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_oct_eval = r_oct_eval;
        n_step     = r_step;
        n_px       = r_px;
        n_py       = r_py;
        n_pz       = r_pz;
        n_a        = r_a;
        n_p0       = r_p0;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_p3       = r_p3;
        n_sum      = r_sum;
        n_valid    = 1'b0;
        n_noise    = r_noise;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_op'(i_operation) == OP_EVAL)) begin
                    n_px       = i_point_x[PW-1:0];
                    n_py       = i_point_y[PW-1:0];
                    n_pz       = i_point_z[PW-1:0];
                    n_k        = '0;
                    n_step     = '0;
                    n_sum      = '0;
                    n_oct_eval = KW'(oct_sat);
                    if (oct_sat == '0) begin
                        n_valid = 1'b1;
                        n_noise = '0;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_step = r_step + 4'd1;
                if (r_step == STEP_ACCUM) begin
                    n_sum  = r_sum + oct_add;
                    n_step = '0;
                    n_k    = r_k + KW'(1);
                    n_px   = {r_px[PW-2:0], 1'b0};
                    n_py   = {r_py[PW-2:0], 1'b0};
                    n_pz   = {r_pz[PW-2:0], 1'b0};
                    if (n_k == r_oct_eval) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_noise = n_sum;
                    end
                end else if (r_step == STEP_DEPTH) begin
                    n_a = lerp_q;
                end else if (r_step == STEP_FACE_HI) begin
                    n_p0 = lerp_q;
                end else if (r_step == STEP_FACE_LO) begin
                    n_p2 = lerp_q;
                end else if (r_step != '0) begin
                    // corner r_step-1 is in the read register
                    if (r_step[0]) begin
                        n_a = r_rdata;
                    end else begin
                        unique case (r_step[2:1])
                            2'd1:    n_p0 = lerp_q;
                            2'd2:    n_p1 = lerp_q;
                            2'd3:    n_p2 = lerp_q;
                            default: n_p3 = lerp_q;
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_octaves <= OCTAVES_RESET;
            r_step    <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_step  <= n_step;
            r_k     <= n_k;
            if (i_cfg_valid && o_cfg_ready) begin
                r_octaves <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct_eval <= n_oct_eval;
        r_px       <= n_px;
        r_py       <= n_py;
        r_pz       <= n_pz;
        r_a        <= n_a;
        r_p0       <= n_p0;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_p3       <= n_p3;
        r_sum      <= n_sum;
        r_noise    <= n_noise;
    end

endmodule

### design/lnt_checker.sv
// ----------------------------------------------------------------------------
// lnt_port_checker
// port level checks of the lattice noise turbulence unit
// ----------------------------------------------------------------------------
module lnt_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_operation,
    input logic o_valid
);
    import lnt_pkg::*;

    // evaluate either runs or answers at once
    a_eval_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (t_op'(i_operation) == OP_EVAL) |=> busy || o_valid)
        else $error("evaluate transaction neither ran nor answered");

    // write gives no result and no busy time
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (t_op'(i_operation) == OP_WRITE) |=> !busy && !o_valid)
        else $error("write transaction caused a result or busy");

    // end of evaluation shows the result
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("not idle after reset");

endmodule

bind lattice_noise_turbulence_unit lnt_port_checker u_lnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_valid     (o_valid)
);
